>>> design/ptc_pkg.sv
// Package with shared types and constants of the periodic timer coalescer.
`timescale 1ns / 1ps

package ptc_pkg;

   localparam int TIME_W  = 32;
   localparam int IVL_W   = 16;
   localparam int IDX_W   = 4;
   localparam int PCT_W   = 7;
   localparam int QNT_W   = 10;
   localparam int COUNT_W = 16;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_ALLOWED_PERCENT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM_STEP    = 1'b1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [PCT_W-1:0]   PERCENT_RESET = 7'd0;
   localparam logic [QNT_W-1:0]   QUANTUM_RESET = 10'd50;
   localparam logic [PCT_W-1:0]   PCT_SCALE     = 7'd100;
   localparam logic [TIME_W-1:0]  TIME_SAT      = 32'hFFFF_FFFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIN,
      ST_DECIDE,
      ST_UPD,
      ST_FINISH
   } ptc_state_type;

   typedef struct packed {
      logic load;
      logic advance;
      logic rd_en;
      logic min_step;
      logic min_first;
      logic decide;
      logic upd_calc;
      logic upd_wr;
      logic finish;
      logic any_active;
   } ptc_cmd_type;

   typedef struct packed {
      logic period_zero;
      logic out_free;
   } ptc_status_type;

endpackage

>>> design/ptc_if.sv
// Valid/ready channel interfaces for load/tick items and result items.
`timescale 1ns / 1ps

interface ptc_req_if import ptc_pkg::*;;
   logic             valid;
   logic             ready;
   logic             operation;
   logic [IDX_W-1:0] client_index;
   logic [IVL_W-1:0] interval;

   modport source (output valid, output operation, output client_index, output interval,
                   input ready);
   modport sink   (input valid, input operation, input client_index, input interval,
                   output ready);
endinterface

interface ptc_rsp_if import ptc_pkg::*;;
   logic               valid;
   logic               ready;
   logic [TIME_W-1:0]  base_time;
   logic               base_valid;
   logic               is_new;
   logic [COUNT_W-1:0] message_count;
   logic [TIME_W-1:0]  current_time;
   logic               time_overflow;

   modport source (output valid, output base_time, output base_valid, output is_new,
                   output message_count, output current_time, output time_overflow,
                   input ready);
   modport sink   (input valid, input base_time, input base_valid, input is_new,
                   input message_count, input current_time, input time_overflow,
                   output ready);
endinterface

>>> design/periodic_timer_coalescer.sv
// Periodic timer coalescer: items in are client loads and time ticks, items out are
// one status result per tick.
//
// req_chan carries an operation, a client slot and an interval. A load is taken in the
// idle state and gives no result. A tick first advances the time, then scans the
// client tables for the earliest due time (one client a cycle, stopping at the first
// zero interval), then walks the active clients again through a two-stage pipeline
// that moves or pulls in their due times. The block returns to idle as the result is
// registered. One item is worked on at a time.
// rsp_chan gets the result from an output register. The next item is accepted while a
// result waits; a tick that finishes while the previous result is still held waits
// for rsp_chan to take it. The user must write csr_ registers only while the block is
// idle; the block itself does not enforce this. Synchronous reset clears the time, the
// counters and all client slots at once and sets the registers to their defaults.
`timescale 1ns / 1ps

module periodic_timer_coalescer import ptc_pkg::*; #(
   parameter int CLIENTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   ptc_req_if.sink               req_chan,
   ptc_rsp_if.source             rsp_chan
);

   localparam int IW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

   ptc_cmd_type    cmd;
   ptc_status_type status;
   logic [IW-1:0]  rd_idx;
   logic [IW-1:0]  wr_idx;

   ptc_ctrl #(.CLIENTS(CLIENTS)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.operation),
      .req_ready     (req_chan.ready),
      .status        (status),
      .cmd           (cmd),
      .rd_idx        (rd_idx),
      .wr_idx        (wr_idx)
   );

   ptc_datapath #(.CLIENTS(CLIENTS)) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_client_index  (req_chan.client_index),
      .req_interval      (req_chan.interval),
      .cmd               (cmd),
      .rd_idx            (rd_idx),
      .wr_idx            (wr_idx),
      .status            (status),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_base_time     (rsp_chan.base_time),
      .rsp_base_valid    (rsp_chan.base_valid),
      .rsp_is_new        (rsp_chan.is_new),
      .rsp_message_count (rsp_chan.message_count),
      .rsp_current_time  (rsp_chan.current_time),
      .rsp_time_overflow (rsp_chan.time_overflow)
   );

`ifndef SYNTHESIS
   // A finished tick never overwrites a result that is still held.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !(rsp_chan.valid && !rsp_chan.ready))
      else $error("result register overwritten");

   // The update pass never reads the slot it writes in the same cycle.
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en && cmd.upd_wr) |-> (rd_idx != wr_idx))
      else $error("table read and write hit the same slot");

   // An accepted tick keeps the input closed until its result is produced.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |=> !req_chan.ready)
      else $error("input accepted while a tick is in progress");
`endif

endmodule

>>> design/ptc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ptc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/ptc_ctrl.sv
// Sequencer for the minimum pass and the update pass of one tick.
`timescale 1ns / 1ps

module ptc_ctrl import ptc_pkg::*; #(
   parameter int CLIENTS = 16,
   localparam int IW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1,
   localparam int CW = $clog2(CLIENTS + 1)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_operation,
   output logic           req_ready,
   input  ptc_status_type status,
   output ptc_cmd_type    cmd,
   output logic [IW-1:0]  rd_idx,
   output logic [IW-1:0]  wr_idx
);

   ptc_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] n_ff, n_in;
   logic          s1_vld_ff, s1_vld_in;
   logic [IW-1:0] s1_idx_ff, s1_idx_in;
   logic          s2_vld_ff, s2_vld_in;
   logic [IW-1:0] s2_idx_ff, s2_idx_in;
   logic          stop;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         n_ff      <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         n_ff      <= n_in;
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= s1_idx_in;
      s2_idx_ff <= s2_idx_in;
   end

   // The scan ends at the first inactive client or after the last slot.
   assign stop = s1_vld_ff && (status.period_zero || (s1_idx_ff == IW'(CLIENTS - 1)));

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      n_in           = n_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      rd_idx         = cnt_ff[IW-1:0];
      wr_idx         = s2_idx_ff;
      cmd.upd_wr     = s2_vld_ff;
      cmd.any_active = (n_ff != '0);

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == OP_TICK) begin
                  cmd.advance = 1'b1;
                  cnt_in      = '0;
                  state_in    = ST_MIN;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_MIN: begin
            if (s1_vld_ff && !status.period_zero) begin
               cmd.min_step  = 1'b1;
               cmd.min_first = (s1_idx_ff == '0);
            end
            if (stop) begin
               n_in     = status.period_zero ? CW'(s1_idx_ff) : CW'(CLIENTS);
               state_in = ST_DECIDE;
            end else if (cnt_ff < CW'(CLIENTS)) begin
               cmd.rd_en = 1'b1;
               cnt_in    = cnt_ff + CW'(1);
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            cnt_in     = '0;
            state_in   = ST_UPD;
         end
         ST_UPD: begin
            if (cnt_ff < n_ff) begin
               cmd.rd_en = 1'b1;
               cnt_in    = cnt_ff + CW'(1);
            end
            if (s1_vld_ff) begin
               cmd.upd_calc = 1'b1;
            end
            if ((cnt_ff == n_ff) && !s1_vld_ff && !s2_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      s1_vld_in = cmd.rd_en;
      s1_idx_in = cnt_ff[IW-1:0];
      s2_vld_in = cmd.upd_calc;
      s2_idx_in = s1_idx_ff;
   end

endmodule

>>> design/ptc_datapath.sv
// Client tables, time keeping, per-client arithmetic and the result register.
`timescale 1ns / 1ps

module ptc_datapath import ptc_pkg::*; #(
   parameter int CLIENTS = 16,
   localparam int IW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  logic [IDX_W-1:0]      req_client_index,
   input  logic [IVL_W-1:0]      req_interval,
   input  ptc_cmd_type           cmd,
   input  logic [IW-1:0]         rd_idx,
   input  logic [IW-1:0]         wr_idx,
   output ptc_status_type        status,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [TIME_W-1:0]     rsp_base_time,
   output logic                  rsp_base_valid,
   output logic                  rsp_is_new,
   output logic [COUNT_W-1:0]    rsp_message_count,
   output logic [TIME_W-1:0]     rsp_current_time,
   output logic                  rsp_time_overflow
);

   localparam int LHS_W = TIME_W + PCT_W;
   localparam int RHS_W = PCT_W + 1 + IVL_W;

   logic [PCT_W-1:0]   pct_ff;
   logic [QNT_W-1:0]   quantum_ff;
   logic [TIME_W-1:0]  now_ff;
   logic               ovf_ff, ovf_in;
   logic [TIME_W-1:0]  min_ff;
   logic               hit_ff;
   logic [TIME_W-1:0]  last_base_ff;
   logic               emitted_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [CLIENTS-1:0] vld_ff;
   logic               rd_vld_ff;

   logic [TIME_W-1:0]  s2_due_ff;
   logic [IVL_W-1:0]   s2_per_ff;
   logic [LHS_W-1:0]   s2_lhs_ff;
   logic [RHS_W-1:0]   s2_rhs_ff;
   logic               s2_eq_now_ff;
   logic               s2_later_ff;
   logic               s2_small_ff;

   logic               out_vld_ff;
   logic [TIME_W-1:0]  out_base_ff;
   logic               out_base_vld_ff;
   logic               out_new_ff;
   logic [COUNT_W-1:0] out_count_ff;
   logic [TIME_W-1:0]  out_now_ff;
   logic               out_ovf_ff;

   logic               load_ok;
   logic [IW-1:0]      load_addr;
   logic [IVL_W-1:0]   per_q;
   logic [TIME_W-1:0]  due_q;
   logic [IVL_W-1:0]   per_rd;
   logic [TIME_W-1:0]  due_rd;
   logic [TIME_W-1:0]  gap;
   logic [PCT_W:0]     pct_plus;
   logic [TIME_W:0]    now_sum;
   logic [TIME_W:0]    due_sum;
   logic               upd_we;
   logic [TIME_W-1:0]  upd_data;
   logic               per_we;
   logic               due_we;
   logic [IW-1:0]      ram_wr_addr;
   logic [TIME_W-1:0]  due_wr_data;
   logic               fresh;
   logic [COUNT_W-1:0] count_next;

   assign load_ok   = cmd.load && (32'(req_client_index) < 32'(CLIENTS));
   assign load_addr = IW'(req_client_index);

   // Both tables are written together by a load, so one valid bit covers a slot.
   assign per_rd = rd_vld_ff ? per_q : '0;
   assign due_rd = rd_vld_ff ? due_q : '0;

   assign gap      = due_rd - min_ff;
   assign pct_plus = {1'b0, pct_ff} + (PCT_W + 1)'(1);
   assign now_sum  = {1'b0, now_ff} + (TIME_W + 1)'(quantum_ff);
   assign due_sum  = {1'b0, s2_due_ff} + (TIME_W + 1)'(s2_per_ff);

   // floor(gap*100/period) <= percent is the same as gap*100 < (percent+1)*period.
   always_comb begin
      if (hit_ff) begin
         upd_we   = s2_eq_now_ff;
         upd_data = due_sum[TIME_W] ? TIME_SAT : due_sum[TIME_W-1:0];
      end else begin
         upd_we   = s2_later_ff && (s2_small_ff || (s2_lhs_ff < LHS_W'(s2_rhs_ff)));
         upd_data = min_ff;
      end
   end

   assign per_we      = load_ok;
   assign due_we      = load_ok || (cmd.upd_wr && upd_we);
   assign ram_wr_addr = cmd.load ? load_addr : wr_idx;
   assign due_wr_data = cmd.load ? TIME_W'(req_interval) : upd_data;

   ptc_ram #(.WIDTH(IVL_W), .DEPTH(CLIENTS)) u_period_ram (
      .clock   (clock),
      .wr_en   (per_we),
      .wr_addr (load_addr),
      .wr_data (req_interval),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_idx),
      .rd_data (per_q)
   );

   ptc_ram #(.WIDTH(TIME_W), .DEPTH(CLIENTS)) u_due_ram (
      .clock   (clock),
      .wr_en   (due_we),
      .wr_addr (ram_wr_addr),
      .wr_data (due_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_idx),
      .rd_data (due_q)
   );

   always_comb begin
      ovf_in = ovf_ff;
      if (cmd.advance && now_sum[TIME_W]) begin
         ovf_in = 1'b1;
      end
      if (cmd.upd_wr && hit_ff && s2_eq_now_ff && due_sum[TIME_W]) begin
         ovf_in = 1'b1;
      end
   end

   assign fresh      = cmd.any_active && (!emitted_ff || (min_ff != last_base_ff));
   assign count_next = (fresh && (count_ff != COUNT_MAX)) ? count_ff + COUNT_W'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pct_ff       <= PERCENT_RESET;
         quantum_ff   <= QUANTUM_RESET;
         now_ff       <= '0;
         ovf_ff       <= 1'b0;
         last_base_ff <= '0;
         emitted_ff   <= 1'b0;
         count_ff     <= '0;
         vld_ff       <= '0;
         out_vld_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_ALLOWED_PERCENT: pct_ff     <= csr_wr_data[PCT_W-1:0];
               CSR_QUANTUM_STEP:    quantum_ff <= csr_wr_data[QNT_W-1:0];
               default:             ;
            endcase
         end
         if (load_ok) begin
            vld_ff[load_addr] <= 1'b1;
         end
         if (cmd.advance) begin
            now_ff <= now_sum[TIME_W] ? TIME_SAT : now_sum[TIME_W-1:0];
         end
         ovf_ff <= ovf_in;
         if (cmd.finish && cmd.any_active) begin
            last_base_ff <= min_ff;
            emitted_ff   <= 1'b1;
            count_ff     <= count_next;
         end
         if (cmd.finish) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_vld_ff <= vld_ff[rd_idx];
      end
      if (cmd.min_step && (cmd.min_first || (due_rd < min_ff))) begin
         min_ff <= due_rd;
      end
      if (cmd.decide) begin
         hit_ff <= (min_ff == now_ff);
      end
      if (cmd.upd_calc) begin
         s2_due_ff    <= due_rd;
         s2_per_ff    <= per_rd;
         s2_lhs_ff    <= LHS_W'(gap) * LHS_W'(PCT_SCALE);
         s2_rhs_ff    <= RHS_W'(pct_plus) * RHS_W'(per_rd);
         s2_eq_now_ff <= (due_rd == now_ff);
         s2_later_ff  <= (due_rd > min_ff);
         s2_small_ff  <= (gap < TIME_W'(quantum_ff));
      end
      if (cmd.finish) begin
         out_base_ff     <= cmd.any_active ? min_ff : '0;
         out_base_vld_ff <= cmd.any_active;
         out_new_ff      <= fresh;
         out_count_ff    <= count_next;
         out_now_ff      <= now_ff;
         out_ovf_ff      <= ovf_ff;
      end
   end

   assign status.period_zero = (per_rd == '0);
   assign status.out_free    = !out_vld_ff || rsp_ready;

   assign rsp_valid         = out_vld_ff;
   assign rsp_base_time     = out_base_ff;
   assign rsp_base_valid    = out_base_vld_ff;
   assign rsp_is_new        = out_new_ff;
   assign rsp_message_count = out_count_ff;
   assign rsp_current_time  = out_now_ff;
   assign rsp_time_overflow = out_ovf_ff;

endmodule
